FILE: hw/rtl/eca_pkg.sv
// Shared types and constants of the energy-weighted centroid table.
package eca_pkg;

   localparam int unsigned SUM_W = 40;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned POS_W = 24;
   localparam int unsigned NRG_W = 24;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned PROD_W = 64;

   localparam int unsigned MUL_STEPS = 24;
   localparam int unsigned DIV_STEPS = 64;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
   localparam logic [POS_W-1:0] POS_MIN = 24'h800000;

   typedef struct packed {
      logic signed [KEY_W-1:0] particle_code;
      logic [NRG_W-1:0] energy_deposit;
      logic signed [POS_W-1:0] position_x;
      logic signed [POS_W-1:0] position_y;
      logic signed [POS_W-1:0] position_z;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] total_energy;
      logic [CNT_W-1:0] total_hit_count;
      logic [SUM_W-1:0] entry_energy;
      logic [CNT_W-1:0] entry_hit_count;
      logic signed [POS_W-1:0] centroid_x;
      logic signed [POS_W-1:0] centroid_y;
      logic signed [POS_W-1:0] centroid_z;
      logic table_full_drop;
   } rsp_type;

endpackage

FILE: hw/rtl/energy_weighted_centroid_table.sv
// Top level: hit lookup table, grand totals and centroid sequencing.
// One item at a time. After start is taken, busy stays high while the table is scanned
// (one key per cycle from the key memory), the entry is read, and, unless the new energy
// sum is zero, the shared centroid unit runs once per axis (24 multiply steps and 64 divide
// steps each). When the table is full and the code is not in it, the item ends after the
// scan. The result appears for one cycle with rsp_strobe and must be taken then; busy is
// already low in that cycle, so the next item may start.
module energy_weighted_centroid_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  eca_pkg::req_type req_item,
   output logic rsp_strobe,
   output eca_pkg::rsp_type rsp_item
);

   localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef struct packed {
      logic [eca_pkg::SUM_W-1:0] sum;
      logic [eca_pkg::CNT_W-1:0] count;
      logic [eca_pkg::POS_W-1:0] cx;
      logic [eca_pkg::POS_W-1:0] cy;
      logic [eca_pkg::POS_W-1:0] cz;
   } ent_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_LOAD, S_CALC, S_WAIT, S_WRITE
   } state_type;

   state_type state_ff;
   eca_pkg::req_type req_ff;
   logic [eca_pkg::SUM_W-1:0] grand_e_ff;
   logic [eca_pkg::CNT_W-1:0] grand_n_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [IDXW:0] scan_ff;
   logic cmp_vld_ff;
   logic [IDXW-1:0] cmp_idx_ff;
   logic [eca_pkg::KEY_W-1:0] key_rd_ff;
   logic hit_ff, free_ff;
   logic [IDXW-1:0] hit_idx_ff, free_idx_ff, sel_ff;
   logic fresh_ff;
   ent_type ent_rd_ff;
   logic [eca_pkg::SUM_W-1:0] old_sum_ff, new_sum_ff;
   logic [eca_pkg::CNT_W-1:0] new_cnt_ff;
   logic [eca_pkg::POS_W-1:0] old_cx_ff, old_cy_ff, old_cz_ff;
   logic [eca_pkg::POS_W-1:0] new_cx_ff, new_cy_ff, new_cz_ff;
   logic [1:0] axis_ff;
   logic wv_start_ff;
   logic rsp_strobe_ff;
   eca_pkg::rsp_type rsp_ff;

   logic [eca_pkg::KEY_W-1:0] key_mem [TABLE_ENTRIES];
   ent_type ent_mem [TABLE_ENTRIES];

   logic cmp_match_in, cmp_free_in, hit_in, free_in;
   logic [IDXW-1:0] hit_idx_in, free_idx_in;
   logic [eca_pkg::SUM_W:0] grand_sum_in, ent_sum_in;
   ent_type old_in;
   logic [eca_pkg::SUM_W-1:0] new_sum_in;
   logic [eca_pkg::POS_W-1:0] wv_old_c, wv_pos;
   logic wv_done;
   logic [eca_pkg::POS_W-1:0] wv_result;

   always_comb begin
      cmp_match_in = cmp_vld_ff && valid_ff[cmp_idx_ff] && (key_rd_ff == req_ff.particle_code);
      cmp_free_in = cmp_vld_ff && !valid_ff[cmp_idx_ff];
      hit_in = hit_ff || cmp_match_in;
      free_in = free_ff || cmp_free_in;
      hit_idx_in = (!hit_ff && cmp_match_in) ? cmp_idx_ff : hit_idx_ff;
      free_idx_in = (!free_ff && cmp_free_in) ? cmp_idx_ff : free_idx_ff;
      grand_sum_in = {1'b0, grand_e_ff} + {17'd0, req_item.energy_deposit};
      old_in = fresh_ff ? '0 : ent_rd_ff;
      ent_sum_in = {1'b0, old_in.sum} + {17'd0, req_ff.energy_deposit};
      new_sum_in = ent_sum_in[eca_pkg::SUM_W] ? eca_pkg::SUM_MAX
                                               : ent_sum_in[eca_pkg::SUM_W-1:0];
      case (axis_ff)
         2'd0: begin
            wv_old_c = old_cx_ff;
            wv_pos = req_ff.position_x;
         end
         2'd1: begin
            wv_old_c = old_cy_ff;
            wv_pos = req_ff.position_y;
         end
         default: begin
            wv_old_c = old_cz_ff;
            wv_pos = req_ff.position_z;
         end
      endcase
   end

   eca_wavg u_wavg (
      .clock   (clock),
      .reset   (reset),
      .start   (wv_start_ff),
      .old_sum (old_sum_ff),
      .old_c   (wv_old_c),
      .nrg     (req_ff.energy_deposit),
      .pos     (wv_pos),
      .new_sum (new_sum_ff),
      .done    (wv_done),
      .result  (wv_result)
   );

   // Table memories: one read port each, registered, and one write port.
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && scan_ff < (IDXW+1)'(TABLE_ENTRIES)) begin
         key_rd_ff <= key_mem[scan_ff[IDXW-1:0]];
      end
      if (state_ff == S_READ) begin
         ent_rd_ff <= ent_mem[sel_ff];
      end
      if (state_ff == S_WRITE) begin
         key_mem[sel_ff] <= req_ff.particle_code;
         ent_mem[sel_ff] <= {new_sum_ff, new_cnt_ff, new_cx_ff, new_cy_ff, new_cz_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         grand_e_ff <= '0;
         grand_n_ff <= '0;
         valid_ff <= '0;
         cmp_vld_ff <= 1'b0;
         wv_start_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         wv_start_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_item;
                  grand_e_ff <= grand_sum_in[eca_pkg::SUM_W] ? eca_pkg::SUM_MAX
                                                            : grand_sum_in[eca_pkg::SUM_W-1:0];
                  if (grand_n_ff != eca_pkg::CNT_MAX) begin
                     grand_n_ff <= grand_n_ff + 1'b1;
                  end
                  scan_ff <= '0;
                  cmp_vld_ff <= 1'b0;
                  hit_ff <= 1'b0;
                  free_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // The key read in the previous cycle is compared in this one.
               hit_ff <= hit_in;
               free_ff <= free_in;
               hit_idx_ff <= hit_idx_in;
               free_idx_ff <= free_idx_in;
               if (scan_ff < (IDXW+1)'(TABLE_ENTRIES)) begin
                  cmp_idx_ff <= scan_ff[IDXW-1:0];
                  cmp_vld_ff <= 1'b1;
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  cmp_vld_ff <= 1'b0;
                  if (hit_in) begin
                     sel_ff <= hit_idx_in;
                     fresh_ff <= 1'b0;
                     state_ff <= S_READ;
                  end else if (free_in) begin
                     sel_ff <= free_idx_in;
                     fresh_ff <= 1'b1;
                     state_ff <= S_READ;
                  end else begin
                     rsp_ff <= '{total_energy: grand_e_ff, total_hit_count: grand_n_ff,
                                 entry_energy: '0, entry_hit_count: '0, centroid_x: '0,
                                 centroid_y: '0, centroid_z: '0, table_full_drop: 1'b1};
                     rsp_strobe_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               old_sum_ff <= old_in.sum;
               new_sum_ff <= new_sum_in;
               new_cnt_ff <= (old_in.count == eca_pkg::CNT_MAX) ? eca_pkg::CNT_MAX
                                                              : old_in.count + 1'b1;
               old_cx_ff <= old_in.cx;
               old_cy_ff <= old_in.cy;
               old_cz_ff <= old_in.cz;
               new_cx_ff <= old_in.cx;
               new_cy_ff <= old_in.cy;
               new_cz_ff <= old_in.cz;
               axis_ff <= 2'd0;
               state_ff <= (new_sum_in != '0) ? S_CALC : S_WRITE;
            end
            S_CALC: begin
               wv_start_ff <= 1'b1;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (wv_done) begin
                  case (axis_ff)
                     2'd0: new_cx_ff <= wv_result;
                     2'd1: new_cy_ff <= wv_result;
                     default: new_cz_ff <= wv_result;
                  endcase
                  if (axis_ff == 2'd2) begin
                     state_ff <= S_WRITE;
                  end else begin
                     axis_ff <= axis_ff + 2'd1;
                     state_ff <= S_CALC;
                  end
               end
            end
            S_WRITE: begin
               valid_ff[sel_ff] <= 1'b1;
               rsp_ff <= '{total_energy: grand_e_ff, total_hit_count: grand_n_ff,
                           entry_energy: new_sum_ff, entry_hit_count: new_cnt_ff,
                           centroid_x: new_cx_ff, centroid_y: new_cy_ff,
                           centroid_z: new_cz_ff, table_full_drop: 1'b0};
               rsp_strobe_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held for two cycles");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result shown while still busy");

   a_drop_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.table_full_drop |-> rsp_item.entry_hit_count != '0)
      else $error("updated entry shows zero hits");

   a_total_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.total_hit_count != '0)
      else $error("result with zero grand hit count");

endmodule

FILE: hw/rtl/eca_wavg.sv
// Weighted centroid unit: shift-add multiplies and a restoring divide, one bit per cycle.
module eca_wavg (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [eca_pkg::SUM_W-1:0] old_sum,
   input  logic signed [eca_pkg::POS_W-1:0] old_c,
   input  logic [eca_pkg::NRG_W-1:0] nrg,
   input  logic signed [eca_pkg::POS_W-1:0] pos,
   input  logic [eca_pkg::SUM_W-1:0] new_sum,
   output logic done,
   output logic signed [eca_pkg::POS_W-1:0] result
);

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_DIV, S_CLAMP} state_type;

   state_type state_ff;
   logic [5:0] cnt_ff;
   logic [eca_pkg::SUM_W:0] a_hi_ff;
   logic [eca_pkg::POS_W-1:0] a_lo_ff;
   logic [eca_pkg::NRG_W:0] b_hi_ff;
   logic [eca_pkg::POS_W-1:0] b_lo_ff;
   logic [eca_pkg::SUM_W-1:0] mca_ff;
   logic [eca_pkg::NRG_W-1:0] mcb_ff;
   logic [eca_pkg::SUM_W-1:0] div_ff;
   logic an_ff, bn_ff, neg_ff;
   logic [eca_pkg::PROD_W-1:0] qm_ff;
   logic [eca_pkg::SUM_W:0] rem_ff;
   logic done_ff;
   logic [eca_pkg::POS_W-1:0] result_ff;

   logic [eca_pkg::SUM_W:0] sa_in;
   logic [eca_pkg::NRG_W:0] sb_in;
   logic [eca_pkg::PROD_W-1:0] pa_in, pb_in;
   logic [eca_pkg::SUM_W:0] r_in;
   logic qbit_in;

   always_comb begin
      sa_in = a_hi_ff + (a_lo_ff[0] ? {1'b0, mca_ff} : '0);
      sb_in = b_hi_ff + (b_lo_ff[0] ? {1'b0, mcb_ff} : '0);
      pa_in = {a_hi_ff[eca_pkg::SUM_W-1:0], a_lo_ff};
      pb_in = {16'd0, b_hi_ff[eca_pkg::NRG_W-1:0], b_lo_ff};
      r_in = {rem_ff[eca_pkg::SUM_W-1:0], qm_ff[eca_pkg::PROD_W-1]};
      qbit_in = (r_in >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_hi_ff <= '0;
                  b_hi_ff <= '0;
                  a_lo_ff <= old_c[eca_pkg::POS_W-1] ? -old_c : old_c;
                  b_lo_ff <= pos[eca_pkg::POS_W-1] ? -pos : pos;
                  an_ff <= old_c[eca_pkg::POS_W-1];
                  bn_ff <= pos[eca_pkg::POS_W-1];
                  mca_ff <= old_sum;
                  mcb_ff <= nrg;
                  div_ff <= new_sum;
                  cnt_ff <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               a_hi_ff <= {1'b0, sa_in[eca_pkg::SUM_W:1]};
               a_lo_ff <= {sa_in[0], a_lo_ff[eca_pkg::POS_W-1:1]};
               b_hi_ff <= {1'b0, sb_in[eca_pkg::NRG_W:1]};
               b_lo_ff <= {sb_in[0], b_lo_ff[eca_pkg::POS_W-1:1]};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(eca_pkg::MUL_STEPS - 1)) begin
                  state_ff <= S_COMB;
               end
            end
            S_COMB: begin
               // Signed sum of the two products as sign and magnitude.
               if (an_ff == bn_ff) begin
                  qm_ff <= pa_in + pb_in;
                  neg_ff <= an_ff;
               end else if (pa_in >= pb_in) begin
                  qm_ff <= pa_in - pb_in;
                  neg_ff <= an_ff;
               end else begin
                  qm_ff <= pb_in - pa_in;
                  neg_ff <= bn_ff;
               end
               rem_ff <= '0;
               cnt_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= qbit_in ? (r_in - {1'b0, div_ff}) : r_in;
               qm_ff <= {qm_ff[eca_pkg::PROD_W-2:0], qbit_in};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(eca_pkg::DIV_STEPS - 1)) begin
                  state_ff <= S_CLAMP;
               end
            end
            S_CLAMP: begin
               if (neg_ff) begin
                  result_ff <= (qm_ff > 64'd8388608) ? eca_pkg::POS_MIN
                                                      : -qm_ff[eca_pkg::POS_W-1:0];
               end else begin
                  result_ff <= (qm_ff > 64'd8388607) ? eca_pkg::POS_MAX
                                                      : qm_ff[eca_pkg::POS_W-1:0];
               end
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign result = result_ff;

endmodule

FILE: verif/energy_weighted_centroid_table_tb.sv
// Testbench for the energy-weighted centroid table: directed and random hits.
module energy_weighted_centroid_table_tb;

   localparam int ENTRIES = 16;
   localparam int STALL_LIMIT = 20000;

   // Predicts each hit's result and checks the results in arrival order.
   class centroid_scoreboard;
      logic [eca_pkg::SUM_W-1:0] grand_sum;
      logic [eca_pkg::CNT_W-1:0] grand_hits;
      bit slot_used [ENTRIES];
      logic [eca_pkg::KEY_W-1:0] slot_key [ENTRIES];
      logic [eca_pkg::SUM_W-1:0] slot_sum [ENTRIES];
      logic [eca_pkg::CNT_W-1:0] slot_hits [ENTRIES];
      logic signed [eca_pkg::POS_W-1:0] slot_cx [ENTRIES];
      logic signed [eca_pkg::POS_W-1:0] slot_cy [ENTRIES];
      logic signed [eca_pkg::POS_W-1:0] slot_cz [ENTRIES];
      eca_pkg::rsp_type pending [$];
      int errors;

      function new();
         grand_sum = '0;
         grand_hits = '0;
         errors = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i] = 0;
         end
      endfunction

      function automatic logic signed [eca_pkg::POS_W-1:0] blend(
            logic [eca_pkg::SUM_W-1:0] old_sum,
            logic signed [eca_pkg::POS_W-1:0] old_c, logic [eca_pkg::NRG_W-1:0] e,
            logic signed [eca_pkg::POS_W-1:0] p, logic [eca_pkg::SUM_W-1:0] new_sum);
         logic signed [127:0] num;
         logic signed [127:0] q;
         num = $signed({88'd0, old_sum}) * 128'(old_c) + $signed({104'd0, e}) * 128'(p);
         // Signed division in SystemVerilog truncates toward zero.
         q = num / $signed({88'd0, new_sum});
         if (q > 128'sd8388607) return eca_pkg::POS_MAX;
         if (q < -128'sd8388608) return eca_pkg::POS_MIN;
         return q[eca_pkg::POS_W-1:0];
      endfunction

      function void note_hit(eca_pkg::req_type h);
         eca_pkg::rsp_type r;
         int slot;
         int spare;
         logic [eca_pkg::SUM_W:0] acc;
         logic [eca_pkg::SUM_W-1:0] old_sum;
         slot = -1;
         spare = -1;
         acc = {1'b0, grand_sum} + h.energy_deposit;
         grand_sum = acc[eca_pkg::SUM_W] ? eca_pkg::SUM_MAX : acc[eca_pkg::SUM_W-1:0];
         if (grand_hits != eca_pkg::CNT_MAX) grand_hits++;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) begin
               if (slot < 0 && slot_key[i] == h.particle_code) slot = i;
            end else if (spare < 0) begin
               spare = i;
            end
         end
         if (slot < 0 && spare >= 0) begin
            slot = spare;
            slot_used[slot] = 1;
            slot_key[slot] = h.particle_code;
            slot_sum[slot] = '0;
            slot_hits[slot] = '0;
            slot_cx[slot] = '0;
            slot_cy[slot] = '0;
            slot_cz[slot] = '0;
         end
         r = '0;
         r.total_energy = grand_sum;
         r.total_hit_count = grand_hits;
         if (slot < 0) begin
            r.table_full_drop = 1'b1;
         end else begin
            old_sum = slot_sum[slot];
            acc = {1'b0, old_sum} + h.energy_deposit;
            slot_sum[slot] = acc[eca_pkg::SUM_W] ? eca_pkg::SUM_MAX
                                                 : acc[eca_pkg::SUM_W-1:0];
            if (slot_hits[slot] != eca_pkg::CNT_MAX) slot_hits[slot]++;
            if (slot_sum[slot] != 0) begin
               slot_cx[slot] = blend(old_sum, slot_cx[slot], h.energy_deposit,
                                     h.position_x, slot_sum[slot]);
               slot_cy[slot] = blend(old_sum, slot_cy[slot], h.energy_deposit,
                                     h.position_y, slot_sum[slot]);
               slot_cz[slot] = blend(old_sum, slot_cz[slot], h.energy_deposit,
                                     h.position_z, slot_sum[slot]);
            end
            r.entry_energy = slot_sum[slot];
            r.entry_hit_count = slot_hits[slot];
            r.centroid_x = slot_cx[slot];
            r.centroid_y = slot_cy[slot];
            r.centroid_z = slot_cz[slot];
         end
         pending.push_back(r);
      endfunction

      function void check_result(eca_pkg::rsp_type got);
         eca_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.total_energy !== want.total_energy) begin
            $display("%0t: total_energy expected %h actual %h", $time,
                     want.total_energy, got.total_energy);
            errors++;
         end
         if (got.total_hit_count !== want.total_hit_count) begin
            $display("%0t: total_hit_count expected %h actual %h", $time,
                     want.total_hit_count, got.total_hit_count);
            errors++;
         end
         if (got.entry_energy !== want.entry_energy) begin
            $display("%0t: entry_energy expected %h actual %h", $time,
                     want.entry_energy, got.entry_energy);
            errors++;
         end
         if (got.entry_hit_count !== want.entry_hit_count) begin
            $display("%0t: entry_hit_count expected %h actual %h", $time,
                     want.entry_hit_count, got.entry_hit_count);
            errors++;
         end
         if (got.centroid_x !== want.centroid_x) begin
            $display("%0t: centroid_x expected %h actual %h", $time,
                     want.centroid_x, got.centroid_x);
            errors++;
         end
         if (got.centroid_y !== want.centroid_y) begin
            $display("%0t: centroid_y expected %h actual %h", $time,
                     want.centroid_y, got.centroid_y);
            errors++;
         end
         if (got.centroid_z !== want.centroid_z) begin
            $display("%0t: centroid_z expected %h actual %h", $time,
                     want.centroid_z, got.centroid_z);
            errors++;
         end
         if (got.table_full_drop !== want.table_full_drop) begin
            $display("%0t: table_full_drop expected %b actual %b", $time,
                     want.table_full_drop, got.table_full_drop);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   eca_pkg::req_type req_item = '0;
   logic rsp_strobe;
   eca_pkg::rsp_type rsp_item;

   centroid_scoreboard board = new();
   int idle_cycles = 0;

   energy_weighted_centroid_table #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Presents one hit after a random gap and holds it until it is taken. Start is
   // dropped only when a gap comes before the item, so back-to-back items keep it high.
   task automatic send_hit(logic [eca_pkg::KEY_W-1:0] code, logic [eca_pkg::NRG_W-1:0] e,
                           logic [eca_pkg::POS_W-1:0] x, logic [eca_pkg::POS_W-1:0] y,
                           logic [eca_pkg::POS_W-1:0] z);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      req_item <= '{code, e, x, y, z};
      start <= 1;
      do @(posedge clock); while (busy);
      board.note_hit('{code, e, x, y, z});
   endtask

   task automatic send_random(logic [eca_pkg::KEY_W-1:0] code);
      logic [eca_pkg::NRG_W-1:0] e;
      case ($urandom_range(0, 5))
         0: e = '0;
         1: e = '1;
         2: e = eca_pkg::NRG_W'($urandom_range(0, 15));
         default: e = eca_pkg::NRG_W'($urandom);
      endcase
      send_hit(code, e, eca_pkg::POS_W'($urandom), eca_pkg::POS_W'($urandom),
               eca_pkg::POS_W'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: zero-energy fresh entry, extreme keys and positions.
      send_hit(32'h0000_0000, '0, 24'h7FFFFF, 24'h800000, 24'h000001);
      send_hit(32'h0000_0000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
      send_hit(32'h0000_0000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h000000);
      send_hit(32'h0000_0000, '0, 24'h123456, 24'h654321, 24'h000000);
      send_hit(32'h8000_0000, 24'hFFFFFF, 24'h800000, 24'h800000, 24'h800000);
      send_hit(32'h7FFF_FFFF, 24'h000001, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_hit(32'hFFFF_FFFF, 24'h000001, 24'hFFFFFF, 24'h000001, 24'h800000);
      send_hit(32'h8000_0000, 24'h000001, 24'h7FFFFF, 24'h000000, 24'h7FFFFF);

      // Fill the table with distinct codes, then hit it while full.
      for (int i = 0; i < ENTRIES - 4; i++) send_random(32'h1000_0000 + i);
      send_random(32'h5555_AAAA);
      send_random(32'hAAAA_5555);
      send_random(32'h0000_0000);
      send_random(32'h7FFF_FFFF);

      // Random: mostly codes already in the table, some misses while full.
      for (int i = 0; i < 1300; i++) begin
         if ($urandom_range(0, 9) == 0) send_random($urandom);
         else send_random(32'h1000_0000 + $urandom_range(0, ENTRIES - 5));
      end
      start <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: sim.f
hw/rtl/eca_pkg.sv
hw/rtl/eca_wavg.sv
hw/rtl/energy_weighted_centroid_table.sv
verif/energy_weighted_centroid_table_tb.sv
